>>> design/sprite_pixel_collision_defines.svh
// ---------------------------------------------------------------------------
// Sprite pixel collision: assertion macros
// Shared property wrappers, sampled on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef SPRITE_PIXEL_COLLISION_DEFINES_SVH
`define SPRITE_PIXEL_COLLISION_DEFINES_SVH

// same-cycle implication
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/spc_pkg.sv
// ---------------------------------------------------------------------------
// Sprite pixel collision: package
// Sizes, codes, register resets and pixel helpers.
// ---------------------------------------------------------------------------
package spc_pkg;

  localparam int MAX_SIDE    = 64;
  // power of two: scan addresses wrap by truncation
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
  localparam int CNT_W       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  localparam int POS_W      = 12;
  localparam int SIZE_W     = 7;
  localparam int IDX_W      = 12;
  localparam int PIX_W      = 32;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [PIX_W-1:0] ALPHA_MASK_RST = 32'hFF00_0000;
  localparam logic [PIX_W-1:0] COLOR_KEY_RST  = '0;
  localparam logic             ALPHA_CHK_RST  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_CHECK  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_MASK_A  = 3'd0,
    CFG_COLOR_KEY_A   = 3'd1,
    CFG_ALPHA_CHECK_A = 3'd2,
    CFG_ALPHA_MASK_B  = 3'd3,
    CFG_COLOR_KEY_B   = 3'd4,
    CFG_ALPHA_CHECK_B = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BOUND,
    S_SPAN,
    S_BASE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  function automatic logic [SIDE_W-1:0] sat_side(input logic [SIZE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (32'(v) > MAX_SIDE) r = SIDE_W'(MAX_SIDE);
    else r = SIDE_W'(v);
    return r;
  endfunction

  function automatic logic visible(input logic [PIX_W-1:0] px,
                                   input logic [PIX_W-1:0] mask,
                                   input logic [PIX_W-1:0] key,
                                   input logic             chk);
    logic r;
    if (chk && ((px & mask) == '0)) r = 1'b0;
    else r = (px != key);
    return r;
  endfunction

endpackage

>>> design/spc_ram.sv
// ---------------------------------------------------------------------------
// Sprite pixel collision: generic RAM
// Single port, synchronous write, registered read.
// ---------------------------------------------------------------------------
module spc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/sprite_pixel_collision.sv
// ---------------------------------------------------------------------------
// Sprite pixel collision
// Pixel-exact overlap test of two sprites held in two pixel RAMs.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall  | kind, pixel_index, pixel_value, positions, sizes
//  out     | output    | out_valid/out_stall| hit
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
//  Loads do one RAM write per word.
//  A check scans the overlap area one pixel pair per cycle through the
//  single read port of each RAM; a hit ends the scan early and boxes with
//  no overlap skip the scan.
//  Input is stalled while a check runs; loads go on while a result waits.
//  rst is synchronous; pixel RAMs are not cleared.
// ---------------------------------------------------------------------------
`include "sprite_pixel_collision_defines.svh"

module sprite_pixel_collision (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [spc_pkg::KIND_W-1:0]          kind,
  input  logic [spc_pkg::IDX_W-1:0]           pixel_index,
  input  logic [spc_pkg::PIX_W-1:0]           pixel_value,
  input  logic signed [spc_pkg::POS_W-1:0]    pos_ax,
  input  logic signed [spc_pkg::POS_W-1:0]    pos_ay,
  input  logic [spc_pkg::SIZE_W-1:0]          width_a,
  input  logic [spc_pkg::SIZE_W-1:0]          height_a,
  input  logic signed [spc_pkg::POS_W-1:0]    pos_bx,
  input  logic signed [spc_pkg::POS_W-1:0]    pos_by,
  input  logic [spc_pkg::SIZE_W-1:0]          width_b,
  input  logic [spc_pkg::SIZE_W-1:0]          height_b,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit,
  input  logic                                cfg_we,
  input  logic [spc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import spc_pkg::*;

  state_t state, state_next;

  logic [PIX_W-1:0] alpha_mask_a, color_key_a, alpha_mask_b, color_key_b;
  logic             alpha_check_a, alpha_check_b;

  logic signed [POS_W-1:0] ax, ay, bx, by, x0, y0;
  logic signed [POS_W:0]   x1, y1;
  logic [SIDE_W-1:0]       wa, ha, wb, hb, ow, oh, dxa, dya, dxb, dyb;
  logic [ADDR_W-1:0]       rbase_a, rbase_b, addr_a, addr_b;
  logic [CNT_W-1:0]        col, row;
  logic                    hit_res, rd_vld;

  logic signed [POS_W:0]   end_ax, end_ay, end_bx, end_by;
  logic signed [POS_W+1:0] span_x, span_y;
  logic                    empty;
  logic [2*SIDE_W-1:0]     base_a, base_b;
  logic                    col_last, row_last;

  logic              accept, idx_ok, we_a, we_b;
  logic [ADDR_W-1:0] ram_addr_a, ram_addr_b;
  logic [PIX_W-1:0]  rdata_a, rdata_b;
  logic              pix_hit, out_free;

  // bounds and spans
  always_comb begin
    end_ax = (POS_W+1)'(ax) + (POS_W+1)'(wa);
    end_ay = (POS_W+1)'(ay) + (POS_W+1)'(ha);
    end_bx = (POS_W+1)'(bx) + (POS_W+1)'(wb);
    end_by = (POS_W+1)'(by) + (POS_W+1)'(hb);
    span_x = (POS_W+2)'(x1) - (POS_W+2)'(x0);
    span_y = (POS_W+2)'(y1) - (POS_W+2)'(y0);
    // boxes apart give a negative span, touching gives zero
    empty  = (span_x <= 0) || (span_y <= 0);
    base_a = (2*SIDE_W)'(dya) * (2*SIDE_W)'(wa) + (2*SIDE_W)'(dxa);
    base_b = (2*SIDE_W)'(dyb) * (2*SIDE_W)'(wb) + (2*SIDE_W)'(dxb);
    col_last = ((SIDE_W'(col) + 1'b1) == ow);
    row_last = ((SIDE_W'(row) + 1'b1) == oh);
  end

  assign accept     = in_valid && !in_stall;
  assign idx_ok     = (32'(pixel_index) < STORE_DEPTH);
  assign we_a       = accept && (kind == KIND_LOAD_A) && idx_ok;
  assign we_b       = accept && (kind == KIND_LOAD_B) && idx_ok;
  assign ram_addr_a = (state == S_IDLE) ? ADDR_W'(pixel_index) : addr_a;
  assign ram_addr_b = (state == S_IDLE) ? ADDR_W'(pixel_index) : addr_b;

  spc_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .addr  (ram_addr_a),
    .wdata (pixel_value),
    .rdata (rdata_a)
  );

  spc_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .addr  (ram_addr_b),
    .wdata (pixel_value),
    .rdata (rdata_b)
  );

  assign pix_hit  = rd_vld
                 && visible(rdata_a, alpha_mask_a, color_key_a, alpha_check_a)
                 && visible(rdata_b, alpha_mask_b, color_key_b, alpha_check_b);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid && (kind == KIND_CHECK)) state_next = S_BOUND;
      end
      S_BOUND: state_next = S_SPAN;
      S_SPAN: begin
        state_next = empty ? S_DONE : S_BASE;
      end
      S_BASE: state_next = S_SCAN;
      S_SCAN: begin
        if (pix_hit) state_next = S_DONE;
        else if (col_last && row_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rd_vld        <= 1'b0;
      out_valid     <= 1'b0;
      alpha_mask_a  <= ALPHA_MASK_RST;
      color_key_a   <= COLOR_KEY_RST;
      alpha_check_a <= ALPHA_CHK_RST;
      alpha_mask_b  <= ALPHA_MASK_RST;
      color_key_b   <= COLOR_KEY_RST;
      alpha_check_b <= ALPHA_CHK_RST;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN);
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ALPHA_MASK_A:  alpha_mask_a  <= PIX_W'(cfg_data);
          CFG_COLOR_KEY_A:   color_key_a   <= PIX_W'(cfg_data);
          CFG_ALPHA_CHECK_A: alpha_check_a <= cfg_data[0];
          CFG_ALPHA_MASK_B:  alpha_mask_b  <= PIX_W'(cfg_data);
          CFG_COLOR_KEY_B:   color_key_b   <= PIX_W'(cfg_data);
          CFG_ALPHA_CHECK_B: alpha_check_b <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ax <= pos_ax;
        ay <= pos_ay;
        bx <= pos_bx;
        by <= pos_by;
        wa <= sat_side(width_a);
        ha <= sat_side(height_a);
        wb <= sat_side(width_b);
        hb <= sat_side(height_b);
      end
      S_BOUND: begin
        x0 <= (ax > bx) ? ax : bx;
        y0 <= (ay > by) ? ay : by;
        x1 <= (end_ax < end_bx) ? end_ax : end_bx;
        y1 <= (end_ay < end_by) ? end_ay : end_by;
      end
      S_SPAN: begin
        ow      <= SIDE_W'(span_x);
        oh      <= SIDE_W'(span_y);
        dxa     <= SIDE_W'(x0 - ax);
        dya     <= SIDE_W'(y0 - ay);
        dxb     <= SIDE_W'(x0 - bx);
        dyb     <= SIDE_W'(y0 - by);
        hit_res <= 1'b0;
      end
      S_BASE: begin
        rbase_a <= ADDR_W'(base_a);
        rbase_b <= ADDR_W'(base_b);
        addr_a  <= ADDR_W'(base_a);
        addr_b  <= ADDR_W'(base_b);
        col     <= '0;
        row     <= '0;
      end
      S_SCAN: begin
        if (pix_hit) hit_res <= 1'b1;
        if (col_last) begin
          col     <= '0;
          row     <= row + 1'b1;
          rbase_a <= rbase_a + ADDR_W'(wa);
          rbase_b <= rbase_b + ADDR_W'(wb);
          addr_a  <= rbase_a + ADDR_W'(wa);
          addr_b  <= rbase_b + ADDR_W'(wb);
        end else begin
          col    <= col + 1'b1;
          addr_a <= addr_a + 1'b1;
          addr_b <= addr_b + 1'b1;
        end
      end
      S_DRAIN: begin
        hit_res <= pix_hit;
      end
      S_DONE: begin
        if (out_free) hit <= hit_res;
      end
      default: ;
    endcase
  end

  `SPC_ASSERT_NOW(a_scan_in_range, state == S_SCAN,
    (SIDE_W'(col) < ow) && (SIDE_W'(row) < oh), "scan counter outside overlap")
  `SPC_ASSERT_NOW(a_read_from_scan, rd_vld,
    $past(state) == S_SCAN, "pixel read valid without scan")
  `SPC_ASSERT_NEXT(a_check_starts, accept && (kind == KIND_CHECK),
    state == S_BOUND, "accepted check did not start")

endmodule

>>> verif/tb_sprite_pixel_collision.sv
// ---------------------------------------------------------------------------
// Sprite pixel collision: testbench
// Loads both pixel RAMs, then sends checks mostly placed near or across each
// other's boxes. A scoreboard keeps its own copy of the RAMs and registers and
// compares every hit word in order. Registers change between phases. Sender
// gaps and receiver stalls vary per phase.
// ---------------------------------------------------------------------------
package spc_tb_pkg;
  import spc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        index;
    logic [PIX_W-1:0]        value;
    logic signed [POS_W-1:0] ax;
    logic signed [POS_W-1:0] ay;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
    logic [SIZE_W-1:0]       wa;
    logic [SIZE_W-1:0]       ha;
    logic [SIZE_W-1:0]       wb;
    logic [SIZE_W-1:0]       hb;
  } word_t;

  class collision_scoreboard;
    bit [PIX_W-1:0] store_a [STORE_DEPTH];
    bit [PIX_W-1:0] store_b [STORE_DEPTH];
    bit written_a [STORE_DEPTH];
    bit written_b [STORE_DEPTH];
    logic [PIX_W-1:0] mask_a, key_a, mask_b, key_b;
    logic chk_a, chk_b;
    bit hits_due [$];
    int failures;

    function new();
      mask_a = ALPHA_MASK_RST;
      key_a = COLOR_KEY_RST;
      chk_a = ALPHA_CHK_RST;
      mask_b = ALPHA_MASK_RST;
      key_b = COLOR_KEY_RST;
      chk_b = ALPHA_CHK_RST;
      failures = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
      case (r)
        CFG_ALPHA_MASK_A:  mask_a = d;
        CFG_COLOR_KEY_A:   key_a = d;
        CFG_ALPHA_CHECK_A: chk_a = d[0];
        CFG_ALPHA_MASK_B:  mask_b = d;
        CFG_COLOR_KEY_B:   key_b = d;
        CFG_ALPHA_CHECK_B: chk_b = d[0];
        default: ;
      endcase
    endfunction

    static function int clip_side(logic [SIZE_W-1:0] v);
      return (int'(v) > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    static function bit shows(input logic [PIX_W-1:0] px, mask, key, input logic chk);
      if (chk && ((px & mask) == '0)) return 1'b0;
      return px != key;
    endfunction

    // walks the whole overlap; loaded drops if any word read was never written
    function void scan_overlap(input word_t w, output bit found, output bit loaded);
      int ax, ay, bx, by, wa, ha, wb, hb, x0, x1, y0, y1, ia, ib;
      ax = int'(w.ax);
      ay = int'(w.ay);
      bx = int'(w.bx);
      by = int'(w.by);
      wa = clip_side(w.wa);
      ha = clip_side(w.ha);
      wb = clip_side(w.wb);
      hb = clip_side(w.hb);
      found = 1'b0;
      loaded = 1'b1;
      if (ax + wa < bx || ax > bx + wb || ay + ha < by || by + hb < ay) return;
      x0 = (ax > bx) ? ax : bx;
      x1 = (ax + wa < bx + wb) ? ax + wa : bx + wb;
      y0 = (ay > by) ? ay : by;
      y1 = (ay + ha < by + hb) ? ay + ha : by + hb;
      for (int x = x0; x < x1; x++) begin
        for (int y = y0; y < y1; y++) begin
          ia = ((y - ay) * wa + (x - ax)) % STORE_DEPTH;
          ib = ((y - by) * wb + (x - bx)) % STORE_DEPTH;
          if (!written_a[ia] || !written_b[ib]) loaded = 1'b0;
          if (shows(store_a[ia], mask_a, key_a, chk_a) &&
              shows(store_b[ib], mask_b, key_b, chk_b)) found = 1'b1;
        end
      end
    endfunction

    function void note_word(word_t w);
      bit found, loaded;
      case (w.kind)
        KIND_LOAD_A: begin
          store_a[w.index] = w.value;
          written_a[w.index] = 1'b1;
        end
        KIND_LOAD_B: begin
          store_b[w.index] = w.value;
          written_b[w.index] = 1'b1;
        end
        KIND_CHECK: begin
          scan_overlap(w, found, loaded);
          hits_due = {hits_due, found};
        end
        default: ;
      endcase
    endfunction

    function void fail_note(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_hit(logic got);
      bit want;
      if (hits_due.size() == 0) begin
        fail_note($sformatf("hit word %b with none expected", got));
        return;
      end
      want = hits_due.pop_front();
      if (got !== want) fail_note($sformatf("hit mismatch: expected %0b, got %b", want, got));
    endfunction

    function int pending();
      return hits_due.size();
    endfunction
  endclass
endpackage

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spc_pkg::*;
  import spc_tb_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int PHASE_ITEMS = 130;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [IDX_W-1:0] pixel_index = '0;
  logic [PIX_W-1:0] pixel_value = '0;
  logic signed [POS_W-1:0] pos_ax = '0, pos_ay = '0, pos_bx = '0, pos_by = '0;
  logic [SIZE_W-1:0] width_a = '0, height_a = '0, width_b = '0, height_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  collision_scoreboard sb;
  int send_idle_pct = 24;
  int stall_pct = 47;
  int quiet_cycles = 0;
  int word_count = 0;

  sprite_pixel_collision dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_word(word_t'{kind, pixel_index, pixel_value, pos_ax, pos_ay, pos_bx, pos_by,
                             width_a, height_a, width_b, height_b});
      if (out_valid && !out_stall) sb.check_hit(hit);
      quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0
                      : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("sprite_pixel_collision test failed");
    $finish;
  end

  task automatic drive_word(word_t w);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    kind <= w.kind;
    pixel_index <= w.index;
    pixel_value <= w.value;
    pos_ax <= w.ax;
    pos_ay <= w.ay;
    pos_bx <= w.bx;
    pos_by <= w.by;
    width_a <= w.wa;
    height_a <= w.ha;
    width_b <= w.wb;
    height_b <= w.hb;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (w.kind != KIND_UNUSED) word_count++;
  endtask

  function automatic word_t random_word();
    word_t w;
    w.kind = KIND_UNUSED;
    w.index = IDX_W'($urandom);
    w.value = $urandom;
    w.ax = POS_W'($urandom);
    w.ay = POS_W'($urandom);
    w.bx = POS_W'($urandom);
    w.by = POS_W'($urandom);
    w.wa = SIZE_W'($urandom_range(127));
    w.ha = SIZE_W'($urandom_range(127));
    w.wb = SIZE_W'($urandom_range(127));
    w.hb = SIZE_W'($urandom_range(127));
    return w;
  endfunction

  function automatic word_t load_word(logic [KIND_W-1:0] k, int idx, logic [PIX_W-1:0] v);
    word_t w;
    w = random_word();
    w.kind = k;
    w.index = IDX_W'(idx);
    w.value = v;
    return w;
  endfunction

  function automatic word_t box_pair(int ax, ay, wa, ha, bx, by, wb, hb);
    word_t w;
    w = random_word();
    w.kind = KIND_CHECK;
    w.ax = POS_W'(ax);
    w.ay = POS_W'(ay);
    w.wa = SIZE_W'(wa);
    w.ha = SIZE_W'(ha);
    w.bx = POS_W'(bx);
    w.by = POS_W'(by);
    w.wb = SIZE_W'(wb);
    w.hb = SIZE_W'(hb);
    return w;
  endfunction

  // moves box B clear of A when the scan would read a never-loaded word
  task automatic send_check(word_t w);
    bit found, loaded;
    w.kind = KIND_CHECK;
    sb.scan_overlap(w, found, loaded);
    if (!loaded) w.bx = POS_W'((w.ax > 0) ? int'(w.ax) - 100 : int'(w.ax) + 100);
    drive_word(w);
  endtask

  function automatic logic [PIX_W-1:0] make_pixel(bit for_b, int dens);
    logic [PIX_W-1:0] mask, key, v;
    logic chk;
    mask = for_b ? sb.mask_b : sb.mask_a;
    key = for_b ? sb.key_b : sb.key_a;
    chk = for_b ? sb.chk_b : sb.chk_a;
    v = $urandom;
    if ($urandom_range(99) < dens) begin
      if (chk && ((v & mask) == '0)) v = v | (mask & (~mask + 1'b1));
      if (v == key) v = v ^ 32'h1;
    end else begin
      case ($urandom_range(2))
        0: v = key;
        1: v = v & ~mask;
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic stray_word();
    word_t w;
    w = random_word();
    if ($urandom_range(9) != 0) w.kind = $urandom_range(1) ? KIND_LOAD_B : KIND_LOAD_A;
    drive_word(w);
  endtask

  task automatic load_sprite(bit to_b, int area, int dens);
    for (int i = 0; i < area; i++) begin
      drive_word(load_word(to_b ? KIND_LOAD_B : KIND_LOAD_A, i, make_pixel(to_b, dens)));
      if ($urandom_range(19) == 0) stray_word();
    end
  endtask

  task automatic near_check(int wa, ha, wb, hb);
    word_t w;
    int ax, ay, dx, dy;
    ax = int'($urandom_range(4000)) - 2000;
    ay = int'($urandom_range(4000)) - 2000;
    dx = int'($urandom_range(wa + wb)) - wb;
    dy = int'($urandom_range(ha + hb)) - hb;
    if ($urandom_range(7) == 0) dx += $urandom_range(1) ? int'($urandom_range(1, 8))
                                                         : -int'($urandom_range(1, 8));
    if ($urandom_range(7) == 0) dy += $urandom_range(1) ? int'($urandom_range(1, 8))
                                                         : -int'($urandom_range(1, 8));
    w = box_pair(ax, ay, wa, ha, ax + dx, ay + dy, wb, hb);
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: w.wa = SIZE_W'($urandom_range(1) ? 0 : $urandom_range(65, 127));
        1: w.ha = SIZE_W'($urandom_range(1) ? 0 : $urandom_range(65, 127));
        2: w.wb = SIZE_W'($urandom_range(1) ? 0 : $urandom_range(65, 127));
        default: w.hb = SIZE_W'($urandom_range(1) ? 0 : $urandom_range(65, 127));
      endcase
    end
    send_check(w);
  endtask

  function automatic void pick_dims(output int w, output int h);
    case ($urandom_range(11))
      0: begin
        w = MAX_SIDE;
        h = $urandom_range(1, 3);
      end
      1: begin
        w = $urandom_range(1, 16);
        h = $urandom_range(1, 16);
      end
      default: begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end
    endcase
  endfunction

  task automatic run_phase(int target);
    int wa, ha, wb, hb;
    word_count = 0;
    while (word_count < target) begin
      pick_dims(wa, ha);
      pick_dims(wb, hb);
      load_sprite(1'b0, wa * ha, $urandom_range(5, 90));
      load_sprite(1'b1, wb * hb, $urandom_range(5, 90));
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(6) == 0) send_check(random_word());
        else near_check(wa, ha, wb, hb);
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic apply_setting(int n);
    logic [CFG_DATA_W-1:0] v [6];
    cfg_reg_t r;
    foreach (v[i]) v[i] = $urandom;
    case (n)
      0: v = '{ALPHA_MASK_RST, COLOR_KEY_RST, CFG_DATA_W'(ALPHA_CHK_RST),
               ALPHA_MASK_RST, COLOR_KEY_RST, CFG_DATA_W'(ALPHA_CHK_RST)};
      1: v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, v[4], 32'h1};
      2: v = '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFE};
      4: v = '{32'h0, v[1], 32'hFFFF_FFFF, v[3], v[4], v[5]};
      default: ;
    endcase
    r = r.first();
    repeat (r.num()) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= r;
      cfg_data <= v[r];
      sb.set_reg(r, v[r]);
      r = r.next();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed();
    word_t w;
    drive_word(load_word(KIND_LOAD_A, 0, 32'hFF12_3456));
    drive_word(load_word(KIND_LOAD_A, 1, 32'h00AB_CDEF));
    drive_word(load_word(KIND_LOAD_A, 2, 32'h0000_0000));
    drive_word(load_word(KIND_LOAD_A, 3, 32'hFFFF_FFFF));
    drive_word(load_word(KIND_LOAD_A, 4095, 32'h7FFF_FFFF));
    drive_word(load_word(KIND_LOAD_B, 0, 32'h0000_0000));
    drive_word(load_word(KIND_LOAD_B, 1, 32'h8000_0000));
    drive_word(load_word(KIND_LOAD_B, 2, 32'h0100_0001));
    drive_word(load_word(KIND_LOAD_B, 3, 32'hFFFF_FFFF));
    send_check(box_pair(0, 0, 2, 2, 0, 0, 2, 2));
    send_check(box_pair(0, 0, 2, 2, 2, 0, 2, 2));
    send_check(box_pair(0, 0, 2, 2, 0, 2, 2, 2));
    send_check(box_pair(0, 0, 2, 2, -2, 0, 2, 2));
    send_check(box_pair(0, 0, 2, 2, 3, 0, 2, 2));
    send_check(box_pair(0, 0, 2, 2, 1, 1, 2, 2));
    send_check(box_pair(0, 0, 0, 2, 0, 0, 2, 2));
    send_check(box_pair(0, 0, 2, 2, 0, 0, 2, 0));
    send_check(box_pair(0, 0, 127, 1, 0, 0, 2, 2));
    send_check(box_pair(-2048, -2048, 2, 2, 2047, 2047, 2, 2));
    send_check(box_pair(2047, 2047, 2, 2, 2047, 2047, 2, 2));
    send_check(box_pair(-2048, -2048, 2, 2, -2047, -2048, 1, 1));
    w = random_word();
    drive_word(w);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 24 : (p < 4) ? 47 : 0;
      stall_pct = (p < 2) ? 47 : (p < 4) ? 24 : 0;
      settle();
      apply_setting(p);
      if (p == 0) directed();
      run_phase(PHASE_ITEMS);
    end
    settle();
    if (sb.failures == 0) $display("sprite_pixel_collision test passed");
    else $display("sprite_pixel_collision test failed");
    $finish;
  end
endmodule

>>> sprite_pixel_collision.f
+incdir+design
design/spc_pkg.sv
design/spc_ram.sv
design/sprite_pixel_collision.sv
verif/tb_sprite_pixel_collision.sv
